>>> rtl/aliquot_sum_perfect_test_macros.svh
// Assertion macros used by the checker file.
`ifndef ALIQUOT_SUM_PERFECT_TEST_MACROS_SVH
`define ALIQUOT_SUM_PERFECT_TEST_MACROS_SVH

// same-cycle implication
`define ASPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/aspt_pkg.sv
`default_nettype none
package aspt_pkg;

	localparam int VALUE_BITS_DEF = 16;
	localparam int NUMBER_W       = 16;
	localparam int SUM_W          = 18;
	// headroom of the running divisor total over the number width
	localparam int ACC_EXTRA      = 4;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic idle;
		logic res_valid;
	} seq_stat_t;

endpackage
`default_nettype wire

>>> rtl/aspt_div.sv
`default_nettype none
module aspt_div #(
	parameter int W = aspt_pkg::VALUE_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [W-1:0]      dividend,
	input  wire logic [W-1:0]      divisor,
	output aspt_pkg::div_stat_t    stat,
	output logic      [W-1:0]      quotient,
	output logic      [W-1:0]      remainder
);

	localparam int CW = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]    shifted;
	logic [W:0]    diff;
	logic          ge;

	// one quotient bit per cycle, restoring
	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		ge      = (shifted >= {1'b0, dvs_q});
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

>>> rtl/aspt_seq.sv
`default_nettype none
module aspt_seq #(
	parameter int W = aspt_pkg::VALUE_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [W-1:0]               n,
	input  wire logic                       res_take,
	output aspt_pkg::seq_stat_t             stat,
	output logic [aspt_pkg::SUM_W-1:0]      res_sum,
	output logic                            res_perfect,
	output logic                            res_invalid
);

	localparam int A  = W + aspt_pkg::ACC_EXTRA;
	localparam int TW = (A > aspt_pkg::SUM_W) ? A : aspt_pkg::SUM_W;
	localparam logic [TW-1:0] SumMax = TW'((64'd1 << aspt_pkg::SUM_W) - 64'd1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ISSUE = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_ADDQ  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]   state_q;
	logic [W-1:0] n_q;
	logic [W-1:0] d_q;
	logic [A-1:0] acc_q;

	logic [W-1:0]        quo;
	logic [W-1:0]        rem;
	aspt_pkg::div_stat_t div_stat;

	logic [A-1:0]  tot;
	logic [TW-1:0] tot_x;

	aspt_div #(.W(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == S_ISSUE),
		.dividend  (n_q),
		.divisor   (d_q),
		.stat      (div_stat),
		.quotient  (quo),
		.remainder (rem)
	);

	// the running total includes the number itself from the pair of d = 1; tot takes it out
	always_comb begin
		tot   = acc_q - A'(n_q);
		tot_x = TW'(tot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (n == '0) ? S_DONE : S_ISSUE;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (div_stat.done) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (quo < d_q) begin
						state_q <= S_FIN;
					end else if (rem == '0) begin
						state_q <= S_ADDQ;
					end else begin
						state_q <= S_ISSUE;
					end
				end
				S_ADDQ: state_q <= S_ISSUE;
				S_FIN:  state_q <= S_DONE;
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q   <= n;
				d_q   <= W'(1);
				acc_q <= '0;
				if (start && n == '0) begin
					res_sum     <= '0;
					res_perfect <= 1'b0;
					res_invalid <= 1'b1;
				end
			end
			S_EVAL: begin
				if (quo >= d_q) begin
					if (rem == '0) begin
						acc_q <= acc_q + A'(d_q);
					end else begin
						d_q <= d_q + W'(1);
					end
				end
			end
			S_ADDQ: begin
				if (quo != d_q) begin
					acc_q <= acc_q + A'(quo);
				end
				d_q <= d_q + W'(1);
			end
			S_FIN: begin
				res_sum     <= (tot_x > SumMax) ? aspt_pkg::SUM_W'(SumMax)
					: aspt_pkg::SUM_W'(tot_x);
				res_perfect <= (tot == A'(n_q));
				res_invalid <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign stat.idle      = (state_q == S_IDLE);
	assign stat.res_valid = (state_q == S_DONE);

endmodule
`default_nettype wire

>>> rtl/aliquot_sum_perfect_test.sv
// channel | signals                                     | word
// --------+---------------------------------------------+----------------------------
// in      | in_valid, in_ready, number                  | number to test
// out     | out_valid, out_ready, divisor_sum,          | proper divisor sum and flags
//         | is_perfect, invalid_input                   |
//
// Divisors are tried in pairs (d, n/d) for d up to floor(sqrt(n)); each trial issues
// the bit-serial divider, waits for it and evaluates quotient and remainder, with an
// extra step to add the paired quotient n/d when d divides n and n/d differs from d.
// Zero skips the divider and goes straight to the result.
// One item is in work at a time; the next is taken once the result leaves for the
// output register, which holds it while out_ready is low.
// arst_n clears all control state; no clearing pass is needed.
`default_nettype none
module aliquot_sum_perfect_test #(
	parameter int VALUE_BITS = aspt_pkg::VALUE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [aspt_pkg::NUMBER_W-1:0] number,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [aspt_pkg::SUM_W-1:0]         divisor_sum,
	output logic                               is_perfect,
	output logic                               invalid_input
);

	aspt_pkg::seq_stat_t         seq_stat;
	logic [VALUE_BITS-1:0]       n_ext;
	logic [aspt_pkg::SUM_W-1:0]  seq_sum;
	logic                        seq_perfect;
	logic                        seq_invalid;
	logic                        res_take;
	logic                        out_valid_q;
	logic [aspt_pkg::SUM_W-1:0]  sum_q;
	logic                        perfect_q;
	logic                        invalid_q;

	always_comb begin
		for (int i = 0; i < VALUE_BITS; i++) begin
			n_ext[i] = (i < aspt_pkg::NUMBER_W) ? number[i % aspt_pkg::NUMBER_W] : 1'b0;
		end
	end

	assign in_ready = seq_stat.idle;
	assign res_take = seq_stat.res_valid && (!out_valid_q || out_ready);

	aspt_seq #(.W(VALUE_BITS)) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_valid && seq_stat.idle),
		.n           (n_ext),
		.res_take    (res_take),
		.stat        (seq_stat),
		.res_sum     (seq_sum),
		.res_perfect (seq_perfect),
		.res_invalid (seq_invalid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_take || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			sum_q     <= seq_sum;
			perfect_q <= seq_perfect;
			invalid_q <= seq_invalid;
		end
	end

	assign out_valid     = out_valid_q;
	assign divisor_sum   = sum_q;
	assign is_perfect    = perfect_q;
	assign invalid_input = invalid_q;

endmodule
`default_nettype wire

>>> rtl/aspt_chk.sv
`default_nettype none
`include "aliquot_sum_perfect_test_macros.svh"
module aspt_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [aspt_pkg::SUM_W-1:0]    divisor_sum,
	input wire logic                          is_perfect,
	input wire logic                          invalid_input
);

	`ASPT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "out word dropped while stalled")
	`ASPT_ASSERT_NOW(a_zero_result, clk, arst_n, out_valid && invalid_input, divisor_sum == '0 && !is_perfect, "zero input gave nonzero result")
	`ASPT_ASSERT_NOW(a_perfect_valid, clk, arst_n, out_valid && is_perfect, !invalid_input && divisor_sum != '0, "perfect flag on invalid word")
	`ASPT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "second word taken while one is in work")

endmodule

bind aliquot_sum_perfect_test aspt_chk u_aspt_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.divisor_sum   (divisor_sum),
	.is_perfect    (is_perfect),
	.invalid_input (invalid_input)
);
`default_nettype wire
